// File: rtl/core/uartrb_pkg.sv
// Shared types and constants of the UART receive/transmit ring buffer block.
`default_nettype none
package uartrb_pkg;

   typedef enum logic [2:0] {
      MODE_LINE_BYTE = 3'd0,
      MODE_POP       = 3'd1,
      MODE_PEEK      = 3'd2,
      MODE_WRITE     = 3'd3,
      MODE_TX_READY  = 3'd4,
      MODE_FLUSH     = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_DROPPED = 2'd2,
      STATUS_TX_FULL = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SRC_NONE    = 2'd0,
      SRC_RX_MEM  = 2'd1,
      SRC_TX_MEM  = 2'd2,
      SRC_TX_BYTE = 2'd3
   } data_src_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_RESP = 2'd2
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

   localparam logic [2:0] ERR_OVERFLOW = 3'b100;
   localparam int COUNT_CALC_W = 10;

endpackage
`default_nettype wire

// File: rtl/core/uartrb_ctrl.sv
// Controller state machine: accept, execute, hold result until transfer.
`default_nettype none
module uartrb_ctrl
   import uartrb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd.load  = 1'b0;
      cmd.exec  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/core/uartrb_dpath.sv
// Datapath: receive and transmit rings, pointers, error latch and drop counter.
`default_nettype none
module uartrb_dpath
   import uartrb_pkg::*;
#(
   parameter int RX_DEPTH = 32,
   parameter int TX_DEPTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_type      cmd,
   input  wire logic [2:0]   req_mode,
   input  wire logic [7:0]   req_rx_byte,
   input  wire logic         req_frame_error,
   input  wire logic         req_line_overrun,
   input  wire logic [7:0]   req_tx_byte,
   output logic [1:0]        rsp_status,
   output logic [7:0]        rsp_data,
   output logic              rsp_data_valid,
   output logic [2:0]        rsp_last_error,
   output logic [4:0]        rsp_rx_count,
   output logic [15:0]       rsp_overflow_count,
   output logic              rsp_tx_active
);

   localparam int RX_PW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int TX_PW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

   function automatic logic [RX_PW-1:0] next_rx(input logic [RX_PW-1:0] p);
      return (p == RX_PW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [TX_PW-1:0] next_tx(input logic [TX_PW-1:0] p);
      return (p == TX_PW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   logic [7:0] rx_mem [RX_DEPTH];
   logic [7:0] tx_mem [TX_DEPTH];

   logic [2:0]       mode_ff;
   logic [7:0]       rx_byte_ff;
   logic             frame_error_ff;
   logic             line_overrun_ff;
   logic [7:0]       tx_byte_ff;

   logic [RX_PW-1:0] rx_wr_ff, rx_wr_in;
   logic [RX_PW-1:0] rx_rd_ff, rx_rd_in;
   logic [TX_PW-1:0] tx_wr_ff, tx_wr_in;
   logic [TX_PW-1:0] tx_rd_ff, tx_rd_in;
   logic [2:0]       err_ff, err_in;
   logic [15:0]      drop_ff, drop_in;
   logic             send_ff, send_in;
   status_type       status_ff, status_in;
   data_src_type     src_ff, src_in;
   logic [7:0]       rx_q_ff;
   logic [7:0]       tx_q_ff;

   logic [RX_PW-1:0] rx_wr_nxt;
   logic [RX_PW-1:0] rx_rd_nxt;
   logic [TX_PW-1:0] tx_wr_nxt;
   logic [TX_PW-1:0] tx_rd_nxt;
   logic             rx_we;
   logic             tx_we;
   logic [COUNT_CALC_W-1:0] count_calc;

   assign rx_wr_nxt = next_rx(rx_wr_ff);
   assign rx_rd_nxt = next_rx(rx_rd_ff);
   assign tx_wr_nxt = next_tx(tx_wr_ff);
   assign tx_rd_nxt = next_tx(tx_rd_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff         <= req_mode;
         rx_byte_ff      <= req_rx_byte;
         frame_error_ff  <= req_frame_error;
         line_overrun_ff <= req_line_overrun;
         tx_byte_ff      <= req_tx_byte;
      end
   end

   always_comb begin
      rx_wr_in  = rx_wr_ff;
      rx_rd_in  = rx_rd_ff;
      tx_wr_in  = tx_wr_ff;
      tx_rd_in  = tx_rd_ff;
      err_in    = err_ff;
      drop_in   = drop_ff;
      send_in   = send_ff;
      status_in = STATUS_DONE;
      src_in    = SRC_NONE;
      rx_we     = 1'b0;
      tx_we     = 1'b0;
      case (mode_ff)
         MODE_LINE_BYTE: begin
            if (rx_wr_nxt == rx_rd_ff) begin
               err_in    = ERR_OVERFLOW;
               drop_in   = drop_ff + 16'd1;
               status_in = STATUS_DROPPED;
            end else begin
               err_in   = {1'b0, line_overrun_ff, frame_error_ff};
               rx_we    = 1'b1;
               rx_wr_in = rx_wr_nxt;
            end
         end
         MODE_POP, MODE_PEEK: begin
            if (rx_wr_ff == rx_rd_ff) begin
               status_in = STATUS_EMPTY;
            end else begin
               src_in = SRC_RX_MEM;
               if (mode_ff == MODE_POP) begin
                  rx_rd_in = rx_rd_nxt;
               end
            end
         end
         MODE_WRITE: begin
            if (tx_wr_nxt == tx_rd_ff) begin
               status_in = STATUS_TX_FULL;
            end else begin
               tx_we    = 1'b1;
               tx_wr_in = tx_wr_nxt;
               send_in  = 1'b1;
               src_in   = SRC_TX_BYTE;
            end
         end
         MODE_TX_READY: begin
            if (tx_wr_ff != tx_rd_ff) begin
               tx_rd_in = tx_rd_nxt;
               src_in   = SRC_TX_MEM;
            end else begin
               send_in   = 1'b0;
               status_in = STATUS_EMPTY;
            end
         end
         MODE_FLUSH: begin
            rx_wr_in = rx_rd_ff;
         end
         default: begin
            status_in = STATUS_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wr_ff <= '0;
         rx_rd_ff <= '0;
         tx_wr_ff <= '0;
         tx_rd_ff <= '0;
         err_ff   <= '0;
         drop_ff  <= '0;
         send_ff  <= 1'b0;
      end else if (cmd.exec) begin
         rx_wr_ff <= rx_wr_in;
         rx_rd_ff <= rx_rd_in;
         tx_wr_ff <= tx_wr_in;
         tx_rd_ff <= tx_rd_in;
         err_ff   <= err_in;
         drop_ff  <= drop_in;
         send_ff  <= send_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         src_ff    <= src_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (rx_we) begin
            rx_mem[rx_wr_nxt] <= rx_byte_ff;
         end
         rx_q_ff <= rx_mem[rx_rd_nxt];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (tx_we) begin
            tx_mem[tx_wr_nxt] <= tx_byte_ff;
         end
         tx_q_ff <= tx_mem[tx_rd_nxt];
      end
   end

   assign count_calc = COUNT_CALC_W'(rx_wr_ff) - COUNT_CALC_W'(rx_rd_ff)
                     + ((rx_wr_ff < rx_rd_ff) ? COUNT_CALC_W'(RX_DEPTH) : '0);

   always_comb begin
      case (src_ff)
         SRC_RX_MEM:  rsp_data = rx_q_ff;
         SRC_TX_MEM:  rsp_data = tx_q_ff;
         SRC_TX_BYTE: rsp_data = tx_byte_ff;
         default:     rsp_data = 8'd0;
      endcase
   end

   assign rsp_status         = status_ff;
   assign rsp_data_valid     = (src_ff != SRC_NONE);
   assign rsp_last_error     = err_ff;
   assign rsp_rx_count       = count_calc[4:0];
   assign rsp_overflow_count = drop_ff;
   assign rsp_tx_active      = send_ff;

endmodule
`default_nettype wire

// File: rtl/core/uart_rx_tx_ring_buffers_core.sv
// Top level of the UART receive/transmit ring buffer block.
// Requests are registered at their transfer; the execute state reads and writes the ring
// memory, then the result register holds the result until its transfer.
// No new request is taken until the result has transferred; the controller takes the next
// request in the cycle after the result transfer. Its execute and result states set this.
// Reset (synchronous): clears ring pointers, error latch, drop counter and
// transmit-active flag; ring contents are not cleared.
`default_nettype none
module uart_rx_tx_ring_buffers_core
   import uartrb_pkg::*;
#(
   parameter int RX_DEPTH = 32,
   parameter int TX_DEPTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [2:0]   req_mode,
   input  wire logic [7:0]   req_rx_byte,
   input  wire logic         req_frame_error,
   input  wire logic         req_line_overrun,
   input  wire logic [7:0]   req_tx_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [7:0]        rsp_data,
   output logic              rsp_data_valid,
   output logic [2:0]        rsp_last_error,
   output logic [4:0]        rsp_rx_count,
   output logic [15:0]       rsp_overflow_count,
   output logic              rsp_tx_active
);

   cmd_type cmd;

   uartrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   uartrb_dpath #(
      .RX_DEPTH (RX_DEPTH),
      .TX_DEPTH (TX_DEPTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_mode           (req_mode),
      .req_rx_byte        (req_rx_byte),
      .req_frame_error    (req_frame_error),
      .req_line_overrun   (req_line_overrun),
      .req_tx_byte        (req_tx_byte),
      .rsp_status         (rsp_status),
      .rsp_data           (rsp_data),
      .rsp_data_valid     (rsp_data_valid),
      .rsp_last_error     (rsp_last_error),
      .rsp_rx_count       (rsp_rx_count),
      .rsp_overflow_count (rsp_overflow_count),
      .rsp_tx_active      (rsp_tx_active)
   );

endmodule
`default_nettype wire

// File: tb/sv/uart_rx_tx_ring_buffers_check.sv
`timescale 1ns / 1ps
// Checker for the UART ring buffer core: predicts every response from the request transfers.
module uart_rx_tx_ring_buffers_check
   import uartrb_pkg::*;
#(
   parameter int RX_DEPTH = 32,
   parameter int TX_DEPTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_ready,
   input  wire logic [2:0]   req_mode,
   input  wire logic [7:0]   req_rx_byte,
   input  wire logic         req_frame_error,
   input  wire logic         req_line_overrun,
   input  wire logic [7:0]   req_tx_byte,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_ready,
   input  wire logic [1:0]   rsp_status,
   input  wire logic [7:0]   rsp_data,
   input  wire logic         rsp_data_valid,
   input  wire logic [2:0]   rsp_last_error,
   input  wire logic [4:0]   rsp_rx_count,
   input  wire logic [15:0]  rsp_overflow_count,
   input  wire logic         rsp_tx_active,
   output int unsigned       mismatches,
   output int unsigned       pending,
   output int unsigned       results_checked,
   output int unsigned       drops_seen,
   output int unsigned       refusals_seen
);

   localparam int RXW = $clog2(RX_DEPTH);
   localparam int TXW = $clog2(TX_DEPTH);

   typedef struct packed {
      status_type    status;
      logic [7:0]    data;
      logic          data_valid;
      logic [2:0]    last_error;
      logic [4:0]    rx_count;
      logic [15:0]   overflow_count;
      logic          tx_active;
   } ring_result_type;

   logic [7:0]       rx_ring [RX_DEPTH];
   logic [7:0]       tx_ring [TX_DEPTH];
   logic [RXW-1:0]   rx_wr;
   logic [RXW-1:0]   rx_rd;
   logic [TXW-1:0]   tx_wr;
   logic [TXW-1:0]   tx_rd;
   logic [2:0]       err_latch;
   logic [15:0]      drop_total;
   logic             tx_on;
   ring_result_type  expected_q [$];
   int unsigned      bad_count;
   int unsigned      seen_count;
   int unsigned      drop_tally;
   int unsigned      refuse_tally;

   function automatic logic [RXW-1:0] rx_next(input logic [RXW-1:0] p);
      return (p == RXW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [TXW-1:0] tx_next(input logic [TXW-1:0] p);
      return (p == TXW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic ring_result_type step_rings(input logic [2:0] m, input logic [7:0] rxb,
                                                  input logic fe, input logic dor,
                                                  input logic [7:0] txb);
      ring_result_type r;
      logic [RXW-1:0]  rnp;
      logic [TXW-1:0]  tnp;
      r = '0;
      r.status = STATUS_DONE;
      case (m)
         MODE_LINE_BYTE: begin
            rnp = rx_next(rx_wr);
            if (rnp == rx_rd) begin
               err_latch = ERR_OVERFLOW;
               drop_total = drop_total + 16'd1;
               r.status = STATUS_DROPPED;
            end else begin
               err_latch = {1'b0, dor, fe};
               rx_ring[rnp] = rxb;
               rx_wr = rnp;
            end
         end
         MODE_POP, MODE_PEEK: begin
            if (rx_wr == rx_rd) begin
               r.status = STATUS_EMPTY;
            end else begin
               rnp = rx_next(rx_rd);
               r.data = rx_ring[rnp];
               r.data_valid = 1'b1;
               if (m == MODE_POP) rx_rd = rnp;
            end
         end
         MODE_WRITE: begin
            tnp = tx_next(tx_wr);
            if (tnp == tx_rd) begin
               r.status = STATUS_TX_FULL;
            end else begin
               tx_ring[tnp] = txb;
               tx_wr = tnp;
               tx_on = 1'b1;
               r.data = txb;
               r.data_valid = 1'b1;
            end
         end
         MODE_TX_READY: begin
            if (tx_wr != tx_rd) begin
               tnp = tx_next(tx_rd);
               tx_rd = tnp;
               r.data = tx_ring[tnp];
               r.data_valid = 1'b1;
            end else begin
               tx_on = 1'b0;
               r.status = STATUS_EMPTY;
            end
         end
         MODE_FLUSH: rx_wr = rx_rd;
         default: ;
      endcase
      r.last_error = err_latch;
      r.rx_count = 5'((int'(rx_wr) + RX_DEPTH - int'(rx_rd)) % RX_DEPTH);
      r.overflow_count = drop_total;
      r.tx_active = tx_on;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      bad_count++;
      $display("mismatch: %s", msg);
   endtask

   always @(posedge clock) begin : watch
      ring_result_type want;
      if (reset) begin
         rx_wr = '0;
         rx_rd = '0;
         tx_wr = '0;
         tx_rd = '0;
         err_latch = '0;
         drop_total = '0;
         tx_on = 1'b0;
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("response with nothing outstanding, status %0d",
                                         rsp_status));
            end else begin
               want = expected_q.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("response %0d status %0d, expected %0d",
                                            seen_count, rsp_status, want.status));
               if (rsp_data !== want.data)
                  report_mismatch($sformatf("response %0d data %02h, expected %02h",
                                            seen_count, rsp_data, want.data));
               if (rsp_data_valid !== want.data_valid)
                  report_mismatch($sformatf("response %0d data_valid %0b, expected %0b",
                                            seen_count, rsp_data_valid, want.data_valid));
               if (rsp_last_error !== want.last_error)
                  report_mismatch($sformatf("response %0d last_error %0d, expected %0d",
                                            seen_count, rsp_last_error, want.last_error));
               if (rsp_rx_count !== want.rx_count)
                  report_mismatch($sformatf("response %0d rx_count %0d, expected %0d",
                                            seen_count, rsp_rx_count, want.rx_count));
               if (rsp_overflow_count !== want.overflow_count)
                  report_mismatch($sformatf("response %0d overflow_count %0d, expected %0d",
                                            seen_count, rsp_overflow_count,
                                            want.overflow_count));
               if (rsp_tx_active !== want.tx_active)
                  report_mismatch($sformatf("response %0d tx_active %0b, expected %0b",
                                            seen_count, rsp_tx_active, want.tx_active));
               if (want.status == STATUS_DROPPED) drop_tally++;
               if (want.status == STATUS_TX_FULL) refuse_tally++;
               seen_count++;
            end
         end
         if (req_valid && req_ready)
            expected_q.push_back(step_rings(req_mode, req_rx_byte, req_frame_error,
                                            req_line_overrun, req_tx_byte));
      end
      pending <= expected_q.size();
      mismatches <= bad_count;
      results_checked <= seen_count;
      drops_seen <= drop_tally;
      refusals_seen <= refuse_tally;
   end

endmodule

// File: tb/sv/uart_rx_tx_ring_buffers_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the UART ring buffer core: request stimulus, response stalls and verdict.
module uart_rx_tx_ring_buffers_core_tb;
   import uartrb_pkg::*;

   localparam int RX_DEPTH = 32;
   localparam int TX_DEPTH = 32;
   localparam int IDLE_PCT = 27;
   localparam int ITEM_TARGET = 1100;
   localparam int LIMIT_NS = 400000;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   logic [2:0]    req_mode;
   logic [7:0]    req_rx_byte;
   logic          req_frame_error;
   logic          req_line_overrun;
   logic [7:0]    req_tx_byte;
   logic          rsp_valid;
   logic          rsp_ready;
   logic [1:0]    rsp_status;
   logic [7:0]    rsp_data;
   logic          rsp_data_valid;
   logic [2:0]    rsp_last_error;
   logic [4:0]    rsp_rx_count;
   logic [15:0]   rsp_overflow_count;
   logic          rsp_tx_active;

   bit            no_idle;
   int unsigned   items_sent;
   int unsigned   mismatches;
   int unsigned   pending;
   int unsigned   results_checked;
   int unsigned   drops_seen;
   int unsigned   refusals_seen;

   uart_rx_tx_ring_buffers_core #(
      .RX_DEPTH (RX_DEPTH),
      .TX_DEPTH (TX_DEPTH)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_rx_byte        (req_rx_byte),
      .req_frame_error    (req_frame_error),
      .req_line_overrun   (req_line_overrun),
      .req_tx_byte        (req_tx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_data           (rsp_data),
      .rsp_data_valid     (rsp_data_valid),
      .rsp_last_error     (rsp_last_error),
      .rsp_rx_count       (rsp_rx_count),
      .rsp_overflow_count (rsp_overflow_count),
      .rsp_tx_active      (rsp_tx_active)
   );

   uart_rx_tx_ring_buffers_check #(
      .RX_DEPTH (RX_DEPTH),
      .TX_DEPTH (TX_DEPTH)
   ) u_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_rx_byte        (req_rx_byte),
      .req_frame_error    (req_frame_error),
      .req_line_overrun   (req_line_overrun),
      .req_tx_byte        (req_tx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_data           (rsp_data),
      .rsp_data_valid     (rsp_data_valid),
      .rsp_last_error     (rsp_last_error),
      .rsp_rx_count       (rsp_rx_count),
      .rsp_overflow_count (rsp_overflow_count),
      .rsp_tx_active      (rsp_tx_active),
      .mismatches         (mismatches),
      .pending            (pending),
      .results_checked    (results_checked),
      .drops_seen         (drops_seen),
      .refusals_seen      (refusals_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin
      #(LIMIT_NS);
      $display("timeout with %0d responses outstanding", pending);
      $display("status: fail");
      $finish;
   end

   // call at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(input logic [2:0] m, input logic [7:0] rxb, input logic fe,
                            input logic dor, input logic [7:0] txb);
      if (!no_idle) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
      end
      req_valid = 1'b1;
      req_mode = m;
      req_rx_byte = rxb;
      req_frame_error = fe;
      req_line_overrun = dor;
      req_tx_byte = txb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (m <= MODE_FLUSH) items_sent++;
   endtask

   task automatic send_random(input logic [2:0] m);
      send_item(m, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                8'($urandom_range(255)));
   endtask

   initial begin : stimulus
      int pick;
      int burst;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_LINE_BYTE;
      req_rx_byte = '0;
      req_frame_error = 1'b0;
      req_line_overrun = 1'b0;
      req_tx_byte = '0;
      no_idle = 1'b0;
      items_sent = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty rings, transmitter ready while disabled, then two writes drained until empty
      send_item(MODE_PEEK, 8'h00, 1'b0, 1'b0, 8'h00);
      send_item(MODE_POP, 8'hFF, 1'b1, 1'b1, 8'hFF);
      send_item(MODE_TX_READY, 8'h00, 1'b0, 1'b0, 8'h00);
      send_item(MODE_WRITE, 8'h00, 1'b0, 1'b0, 8'h00);
      send_item(MODE_WRITE, 8'h00, 1'b0, 1'b0, 8'hFF);
      send_item(MODE_TX_READY, 8'hFF, 1'b1, 1'b1, 8'h00);
      send_item(MODE_TX_READY, 8'h00, 1'b0, 1'b0, 8'h00);
      send_item(MODE_TX_READY, 8'h00, 1'b0, 1'b0, 8'h00);
      // line bytes with each error combination, then a peek and pops
      send_item(MODE_LINE_BYTE, 8'hFF, 1'b1, 1'b0, 8'h00);
      send_item(MODE_LINE_BYTE, 8'h00, 1'b0, 1'b1, 8'hFF);
      send_item(MODE_LINE_BYTE, 8'hA5, 1'b1, 1'b1, 8'h00);
      send_item(MODE_LINE_BYTE, 8'h5A, 1'b0, 1'b0, 8'h00);
      send_item(MODE_PEEK, 8'h00, 1'b0, 1'b0, 8'h00);
      send_item(MODE_POP, 8'h00, 1'b0, 1'b0, 8'h00);
      send_item(MODE_POP, 8'h00, 1'b0, 1'b0, 8'h00);
      // unused modes change nothing
      send_item(3'd6, 8'hFF, 1'b1, 1'b1, 8'hFF);
      send_item(3'd7, 8'h00, 1'b0, 1'b0, 8'h00);
      // flush discards what is left
      send_item(MODE_FLUSH, 8'h00, 1'b0, 1'b0, 8'h00);
      send_item(MODE_PEEK, 8'h00, 1'b0, 1'b0, 8'h00);
      send_item(MODE_POP, 8'h00, 1'b0, 1'b0, 8'h00);
      send_item(MODE_FLUSH, 8'h00, 1'b0, 1'b0, 8'h00);

      while (items_sent < ITEM_TARGET) begin
         no_idle = (items_sent >= 500 && items_sent < 700);
         pick = $urandom_range(99);
         burst = $urandom_range(20, 40);
         if (pick < 15)
            repeat (burst) send_random(MODE_LINE_BYTE);
         else if (pick < 30)
            repeat (burst) send_random(($urandom_range(3) != 0) ? MODE_POP : MODE_PEEK);
         else if (pick < 45)
            repeat (burst) send_random(MODE_WRITE);
         else if (pick < 60)
            repeat (burst) send_random(MODE_TX_READY);
         else if (pick < 64)
            send_random(MODE_FLUSH);
         else if (pick < 67)
            send_random(3'($urandom_range(6, 7)));
         else
            send_random(3'($urandom_range(0, 5)));
      end
      req_valid = 1'b0;
      no_idle = 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("ran %0d requests through both rings, %0d responses checked", items_sent,
               results_checked);
      $display("%0d receive drops and %0d refused writes seen, %0d mismatches", drops_seen,
               refusals_seen, mismatches);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
